// File: sv/cpk_pkg.sv
// ----------------------------------------------------------------------------
// cpk_pkg
// Types and constants shared by the cam position and key tick core.
// ----------------------------------------------------------------------------
package cpk_pkg;

    localparam int KEY_COUNT = 3;
    localparam int POS_W     = 10;
    localparam int MOD_W     = 11;
    localparam int DIV_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(720);
    localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);
    localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(1024);
    localparam logic [DIV_W-1:0] DIV_RESET = DIV_W'(40);

    typedef enum logic
    {
        REG_POSITION_MODULUS = 1'b0,
        REG_TICK_DIVIDE      = 1'b1
    } cpk_reg_t;

    typedef struct packed
    {
        logic                 sensor_a_level;
        logic                 sensor_b_level;
        logic                 dc_motor_on;
        logic                 step_phase_odd;
        logic                 direction_forward;
        logic [KEY_COUNT-1:0] key_levels;
        logic [KEY_COUNT-1:0] clear_presses;
    } cpk_in_t;

    typedef struct packed
    {
        logic [POS_W-1:0]     position;
        logic                 cam_pass;
        logic                 periodic_pulse;
        logic                 indicator_level;
        logic [KEY_COUNT-1:0] presses_latched;
        logic [KEY_COUNT-1:0] quick_release;
        logic [KEY_COUNT-1:0] keys_held;
    } cpk_out_t;

endpackage

// File: sv/cpk_in_if.sv
// ----------------------------------------------------------------------------
// cpk_in_if
// Valid/ready channel carrying one tick item into the core.
// ----------------------------------------------------------------------------
interface cpk_in_if;

    logic             valid;
    logic             ready;
    cpk_pkg::cpk_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: sv/cpk_out_if.sv
// ----------------------------------------------------------------------------
// cpk_out_if
// Valid/ready channel carrying one result item out of the core.
// ----------------------------------------------------------------------------
interface cpk_out_if;

    logic              valid;
    logic              ready;
    cpk_pkg::cpk_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: sv/cam_position_key_tick_core.sv
// ----------------------------------------------------------------------------
// cam_position_key_tick_core
// Cam pass tracker, position counter, key scanner and tick divider.
// ----------------------------------------------------------------------------
// One tick item is taken per clock cycle when the result side keeps up; every
// tick yields exactly one result item by way of the input register and then
// the output register. The tick is captured in the input register, the whole
// state update is one shallow pass of logic, and the result sits in the output
// register until taken, so a stalled result stops intake only once both
// registers are full. Configuration registers are written over the APB port:
// position_modulus at 0x0 and tick_divide at 0x4; both read back.
module cam_position_key_tick_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    cpk_in_if.sink                             tick,
    cpk_out_if.source                          result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cpk_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [cpk_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cpk_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import cpk_pkg::*;

    logic [MOD_W-1:0]     mod_reg;
    logic [DIV_W-1:0]     div_cfg_reg;

    cpk_in_t              in_reg;
    logic                 in_valid_reg;
    cpk_out_t             out_reg;
    cpk_out_t             out_next;
    logic                 out_valid_reg;
    logic                 advance;

    logic                 cam_entered_reg;
    logic                 cam_entered_next;
    logic                 cam_firm_reg;
    logic                 cam_firm_next;
    logic                 cam_leaving_reg;
    logic                 cam_leaving_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;
    logic [DIV_W-1:0]     div_cnt_reg;
    logic [DIV_W-1:0]     div_cnt_next;
    logic                 ind_reg;
    logic                 ind_next;
    logic [KEY_COUNT-1:0] key_prev_reg;
    logic [KEY_COUNT-1:0] key_fell_reg;
    logic [KEY_COUNT-1:0] key_fell_next;
    logic [KEY_COUNT-1:0] key_held_next;
    logic [KEY_COUNT-1:0] key_latched_reg;
    logic [KEY_COUNT-1:0] key_latched_next;

    logic                 cfg_write;
    cpk_reg_t             cfg_sel;
    logic                 cam;
    logic                 pass;
    logic                 expire;
    logic [MOD_W-1:0]     mod_eff;
    logic [MOD_W-1:0]     mod_m1;
    logic [MOD_W-1:0]     pos_up;
    logic [POS_W-1:0]     pos_dn;
    logic [POS_W-1:0]     pos_step;
    logic [DIV_W-1:0]     div_dec;
    logic [KEY_COUNT-1:0] pressed;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_sel   = cpk_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_sel)
            REG_POSITION_MODULUS: prdata = APB_DATA_W'(mod_reg);
            REG_TICK_DIVIDE:      prdata = APB_DATA_W'(div_cfg_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg     <= MOD_RESET;
            div_cfg_reg <= DIV_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_sel == REG_POSITION_MODULUS)
            begin
                mod_reg <= pwdata[MOD_W-1:0];
            end
            else
            begin
                div_cfg_reg <= pwdata[DIV_W-1:0];
            end
        end
    end

    // handshake
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign tick.ready   = !in_valid_reg || advance;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_reg <= tick.data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // position step
    always_comb
    begin
        if (mod_reg < MOD_MIN)
        begin
            mod_eff = MOD_MIN;
        end
        else if (mod_reg > MOD_MAX)
        begin
            mod_eff = MOD_MAX;
        end
        else
        begin
            mod_eff = mod_reg;
        end
        mod_m1 = mod_eff - MOD_W'(1);
        pos_up = {1'b0, pos_reg} + MOD_W'(1);
        pos_dn = pos_reg - POS_W'(1);
        if (in_reg.direction_forward)
        begin
            pos_step = (pos_up > mod_m1) ? '0 : pos_up[POS_W-1:0];
        end
        else if (pos_reg == '0)
        begin
            pos_step = mod_m1[POS_W-1:0];
        end
        else
        begin
            pos_step = ({1'b0, pos_dn} > mod_eff) ? mod_m1[POS_W-1:0] : pos_dn;
        end
    end

    // cam pass sequence
    always_comb
    begin
        cam = in_reg.dc_motor_on
            ? (in_reg.sensor_a_level && in_reg.sensor_b_level)
            : (!in_reg.sensor_a_level || !in_reg.sensor_b_level);
        cam_entered_next = cam_entered_reg;
        cam_firm_next    = cam_firm_reg;
        cam_leaving_next = cam_leaving_reg;
        pos_next         = pos_reg;
        pass             = 1'b0;
        if (in_reg.dc_motor_on || in_reg.step_phase_odd)
        begin
            if (cam)
            begin
                if (cam_entered_reg)
                begin
                    cam_firm_next = 1'b1;
                end
                else
                begin
                    cam_entered_next = 1'b1;
                end
            end
            else if (cam_leaving_reg)
            begin
                pos_next         = pos_step;
                cam_leaving_next = 1'b0;
                cam_entered_next = 1'b0;
                cam_firm_next    = 1'b0;
                pass             = 1'b1;
            end
            else if (cam_firm_reg)
            begin
                cam_leaving_next = 1'b1;
            end
            else if (cam_entered_reg)
            begin
                cam_entered_next = 1'b0;
            end
        end
    end

    // keys and divider
    always_comb
    begin
        pressed          = ~in_reg.key_levels;
        key_held_next    = key_fell_reg & pressed;
        key_fell_next    = ~key_prev_reg & pressed;
        key_latched_next = (key_latched_reg & ~in_reg.clear_presses)
                         | (~key_held_next & key_fell_next);
        div_dec          = div_cnt_reg - DIV_W'(1);
        expire           = (div_dec == '0);
        div_cnt_next     = expire ? div_cfg_reg : div_dec;
        ind_next         = ind_reg ^ expire;

        out_next.position        = pos_next;
        out_next.cam_pass        = pass;
        out_next.periodic_pulse  = expire;
        out_next.indicator_level = ind_next;
        out_next.presses_latched = key_latched_next;
        out_next.quick_release   = key_fell_reg & in_reg.key_levels;
        out_next.keys_held       = key_held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_entered_reg <= 1'b0;
            cam_firm_reg    <= 1'b0;
            cam_leaving_reg <= 1'b0;
            pos_reg         <= '0;
            div_cnt_reg     <= DIV_RESET;
            ind_reg         <= 1'b0;
            key_prev_reg    <= '0;
            key_fell_reg    <= '0;
            key_latched_reg <= '0;
        end
        else if (advance)
        begin
            cam_entered_reg <= cam_entered_next;
            cam_firm_reg    <= cam_firm_next;
            cam_leaving_reg <= cam_leaving_next;
            pos_reg         <= pos_next;
            div_cnt_reg     <= div_cnt_next;
            ind_reg         <= ind_next;
            key_prev_reg    <= in_reg.key_levels;
            key_fell_reg    <= key_fell_next;
            key_latched_reg <= key_latched_next;
        end
    end

endmodule

// File: sv/cpk_checker.sv
// ----------------------------------------------------------------------------
// cpk_checker
// Port-level checks of the result stream of the cam position and key core.
// ----------------------------------------------------------------------------
module cpk_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       result_valid,
    input logic                       result_ready,
    input logic [cpk_pkg::POS_W-1:0]  position,
    input logic                       cam_pass,
    input logic                       periodic_pulse,
    input logic                       indicator_level
);
    import cpk_pkg::*;

    logic             out_acc;
    logic [POS_W-1:0] last_pos_reg;
    logic             last_ind_reg;

    assign out_acc = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pos_reg <= '0;
            last_ind_reg <= 1'b0;
        end
        else if (out_acc)
        begin
            last_pos_reg <= position;
            last_ind_reg <= indicator_level;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(position))
        else $error("result item dropped or changed while stalled");

    a_pass_moves: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && cam_pass |-> position != last_pos_reg)
        else $error("cam pass without position step");

    a_no_pass_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !cam_pass |-> position == last_pos_reg)
        else $error("position moved without cam pass");

    a_pulse_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> periodic_pulse == (indicator_level != last_ind_reg))
        else $error("indicator toggle disagrees with periodic pulse");

endmodule

bind cam_position_key_tick_core cpk_checker u_cpk_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .position        (result.data.position),
    .cam_pass        (result.data.cam_pass),
    .periodic_pulse  (result.data.periodic_pulse),
    .indicator_level (result.data.indicator_level)
);
